@@ rtl/lps_pkg.sv @@
package lps_pkg;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam int BYTE_IDX_BITS  = 13;
	localparam int BIT_POS_BITS   = 3;
	localparam int PAGE_DIM_BITS  = 11;
	localparam int LIN_BITS       = 22;
	localparam int CMP_MIN_BITS   = 12;

	typedef struct packed {
		logic last_pixel;
		logic no_line;
	} lps_flags_t;

endpackage

@@ rtl/lps_cmd_if.sv @@
interface lps_cmd_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] finish_x;
	logic signed [COORD_BITS-1:0] finish_y;

	modport source (
		output valid, opcode, start_x, start_y, finish_x, finish_y,
		input  ready
	);

	modport sink (
		input  valid, opcode, start_x, start_y, finish_x, finish_y,
		output ready
	);
endinterface

@@ rtl/lps_pix_if.sv @@
interface lps_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         visible;
	logic [12:0]                  byte_index;
	logic [2:0]                   bit_position;
	logic                         last_pixel;
	logic                         no_line;

	modport source (
		output valid, pixel_x, pixel_y, visible, byte_index, bit_position,
		       last_pixel, no_line,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, visible, byte_index, bit_position,
		       last_pixel, no_line,
		output ready
	);
endinterface

@@ rtl/lps_step.sv @@
module lps_step
	import lps_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lps_cmd_if.sink                      cmd,
	input  logic                         s2_ready,
	output logic                         v_s2,
	output logic signed [COORD_BITS-1:0] x_s2,
	output logic signed [COORD_BITS-1:0] y_s2,
	output lps_flags_t                   flags_s2
);
	localparam int N = COORD_BITS;

	logic                v_s1;
	logic                op_s1;
	logic signed [N-1:0] sx_s1, sy_s1, fx_s1, fy_s1;

	logic signed [N-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [N:0]          dx_q, dy_q;
	logic signed [N+1:0] err_q;
	logic                x_down_q, y_down_q, active_q;

	logic                s2_free, move_s1;
	logic signed [N:0]   dxd, dyd;
	logic [N:0]          dx_ld, dy_ld;
	logic signed [N+1:0] err_ld;
	logic signed [N+2:0] e2, err_w, dx_e, dy_e;
	logic                step_x, step_y;
	logic signed [N-1:0] nx, ny, tx, ty;
	logic [N:0]          ndx, ndy;
	logic signed [N+1:0] nerr;
	logic                nxd, nyd, last, idle_adv;

	assign s2_free   = !v_s2 || s2_ready;
	assign move_s1   = v_s1 && s2_free;
	assign cmd.ready = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1 <= cmd.opcode;
			sx_s1 <= cmd.start_x;
			sy_s1 <= cmd.start_y;
			fx_s1 <= cmd.finish_x;
			fy_s1 <= cmd.finish_y;
		end
	end

	assign dxd    = (N+1)'(fx_s1) - (N+1)'(sx_s1);
	assign dyd    = (N+1)'(fy_s1) - (N+1)'(sy_s1);
	assign dx_ld  = dxd[N] ? (N+1)'(-dxd) : (N+1)'(dxd);
	assign dy_ld  = dyd[N] ? (N+1)'(-dyd) : (N+1)'(dyd);
	assign err_ld = $signed({1'b0, dx_ld}) - $signed({1'b0, dy_ld});

	assign e2     = $signed({err_q, 1'b0});
	assign dx_e   = $signed({2'b00, dx_q});
	assign dy_e   = $signed({2'b00, dy_q});
	assign step_x = e2 > -dy_e;
	assign step_y = e2 < dx_e;
	assign err_w  = (N+3)'(err_q) - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);

	assign idle_adv = (op_s1 == OP_ADVANCE) && !active_q;

	always_comb begin
		tx   = tgt_x_q;
		ty   = tgt_y_q;
		ndx  = dx_q;
		ndy  = dy_q;
		nxd  = x_down_q;
		nyd  = y_down_q;
		nerr = err_q;
		nx   = cur_x_q;
		ny   = cur_y_q;
		case (op_s1)
			OP_LOAD: begin
				nx   = sx_s1;
				ny   = sy_s1;
				tx   = fx_s1;
				ty   = fy_s1;
				ndx  = dx_ld;
				ndy  = dy_ld;
				nxd  = !(sx_s1 < fx_s1);
				nyd  = !(sy_s1 < fy_s1);
				nerr = err_ld;
			end
			OP_ADVANCE: begin
				if (active_q) begin
					nerr = err_w[N+1:0];
					if (step_x) begin
						nx = x_down_q ? cur_x_q - N'(1) : cur_x_q + N'(1);
					end
					if (step_y) begin
						ny = y_down_q ? cur_y_q - N'(1) : cur_y_q + N'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign last = (nx == tx) && (ny == ty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			err_q    <= '0;
			x_down_q <= 1'b0;
			y_down_q <= 1'b0;
			active_q <= 1'b0;
		end else if (move_s1 && !idle_adv) begin
			cur_x_q  <= nx;
			cur_y_q  <= ny;
			tgt_x_q  <= tx;
			tgt_y_q  <= ty;
			dx_q     <= ndx;
			dy_q     <= ndy;
			err_q    <= nerr;
			x_down_q <= nxd;
			y_down_q <= nyd;
			active_q <= !last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			x_s2                <= idle_adv ? '0 : nx;
			y_s2                <= idle_adv ? '0 : ny;
			flags_s2.last_pixel <= !idle_adv && last;
			flags_s2.no_line    <= idle_adv;
		end
	end

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && flags_s2.last_pixel |-> !active_q)
		else $error("line still active after its endpoint");

	a_mid_keeps_line: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !flags_s2.last_pixel && !flags_s2.no_line |-> active_q)
		else $error("line dropped before its endpoint");

	a_idle_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && flags_s2.no_line |-> !active_q && !flags_s2.last_pixel)
		else $error("idle beat while a line is active");
endmodule

@@ rtl/lps_addr.sv @@
module lps_addr
	import lps_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int PAGE_WIDTH  = 384,
	parameter int PAGE_HEIGHT = 96
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         v_s2,
	input  logic signed [COORD_BITS-1:0] x_s2,
	input  logic signed [COORD_BITS-1:0] y_s2,
	input  lps_flags_t                   flags_s2,
	output logic                         s2_ready,
	lps_pix_if.source                    pix
);
	localparam int N  = COORD_BITS;
	localparam int CW = (N > CMP_MIN_BITS) ? N : CMP_MIN_BITS;

	logic                     v_s3;
	logic [CW-1:0]            xu, yu;
	logic                     vis;
	logic [LIN_BITS-1:0]      lin;
	logic [BYTE_IDX_BITS-1:0] byte_idx;
	logic [BIT_POS_BITS-1:0]  bit_pos;

	assign s2_ready = !v_s3 || pix.ready;

	assign xu  = CW'($unsigned(x_s2));
	assign yu  = CW'($unsigned(y_s2));
	assign vis = !flags_s2.no_line && !x_s2[N-1] && !y_s2[N-1] &&
	             (xu < CW'(PAGE_WIDTH)) && (yu < CW'(PAGE_HEIGHT));
	assign lin = LIN_BITS'(yu[PAGE_DIM_BITS-1:0]) * LIN_BITS'(PAGE_WIDTH) +
	             LIN_BITS'(xu[PAGE_DIM_BITS-1:0]);
	assign byte_idx = vis ? lin[BYTE_IDX_BITS+2:3] : '0;
	assign bit_pos  = vis ? BIT_POS_BITS'(7) - lin[2:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s2_ready) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && s2_ready) begin
			pix.pixel_x      <= x_s2;
			pix.pixel_y      <= y_s2;
			pix.visible      <= vis;
			pix.byte_index   <= byte_idx;
			pix.bit_position <= bit_pos;
			pix.last_pixel   <= flags_s2.last_pixel;
			pix.no_line      <= flags_s2.no_line;
		end
	end

	assign pix.valid = v_s3;

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.no_line |-> !pix.visible && !pix.last_pixel &&
		pix.pixel_x == '0 && pix.pixel_y == '0)
		else $error("idle beat carries pixel data");

	a_offpage_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.visible |-> pix.byte_index == '0 && pix.bit_position == '0)
		else $error("address on an off-page pixel");

	a_visible_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.visible |-> !pix.pixel_x[N-1] && !pix.pixel_y[N-1])
		else $error("negative coordinate flagged visible");
endmodule

@@ rtl/line_pixel_stepper.sv @@
// Line pixel stepper.
// cmd channel (sink): one beat per command. opcode load takes start and finish
// points and yields the start pixel; opcode advance yields the next pixel of
// the active line. An advance with no active line yields a beat with no_line
// set and every other field zero.
// pix channel (source): one beat per command, in command order, with the
// pixel coordinates, the on-page flag, packed byte index and bit position
// (MSB first, row-major, eight pixels per byte) and the endpoint flag.
// Pipeline: three register stages (input register, step register holding the
// line state update, address/output register); a command's beat passes them
// in that order, and pix valid rises when it reaches the address/output stage.
// Throughput: one command per cycle while pix.ready is high; the step update
// is two compares and an add on line state; address map: one constant multiply.
// Reset: clears all valid flags and the line state; no line is active.
// Stall: when pix.ready is low the output holds, the upstream stages fill,
// and cmd.ready drops once all three stages hold a beat.
module line_pixel_stepper
	import lps_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int PAGE_WIDTH  = 384,
	parameter int PAGE_HEIGHT = 96
) (
	input  logic       clk,
	input  logic       arst_n,
	lps_cmd_if.sink    cmd,
	lps_pix_if.source  pix
);
	logic                         v_s2;
	logic                         s2_ready;
	logic signed [COORD_BITS-1:0] x_s2;
	logic signed [COORD_BITS-1:0] y_s2;
	lps_flags_t                   flags_s2;

	lps_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s2_ready (s2_ready),
		.v_s2     (v_s2),
		.x_s2     (x_s2),
		.y_s2     (y_s2),
		.flags_s2 (flags_s2)
	);

	lps_addr #(
		.COORD_BITS (COORD_BITS),
		.PAGE_WIDTH (PAGE_WIDTH),
		.PAGE_HEIGHT(PAGE_HEIGHT)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s2     (v_s2),
		.x_s2     (x_s2),
		.y_s2     (y_s2),
		.flags_s2 (flags_s2),
		.s2_ready (s2_ready),
		.pix      (pix)
	);
endmodule

@@ dv/tb_line_pixel_stepper.sv @@
module tb_line_pixel_stepper;
	import lps_pkg::*;

	localparam int COORD_BITS  = 12;
	localparam int PAGE_WIDTH  = 384;
	localparam int PAGE_HEIGHT = 96;
	localparam int ITEM_TOTAL  = 450;
	localparam int HOLD_CYCLES = 64;

	localparam logic [11:0] C_MIN = 12'h800;
	localparam logic [11:0] C_MAX = 12'h7FF;

	typedef struct packed {
		logic [11:0] px;
		logic [11:0] py;
		logic        vis;
		logic [12:0] byte_idx;
		logic [2:0]  bit_pos;
		logic        last;
		logic        no_line;
	} pixel_t;

	typedef struct packed {
		logic        op;
		logic [11:0] sx, sy, fx, fy;
		logic        known;
		pixel_t      want;
	} cmd_row_t;

	localparam pixel_t NO_LINE_PIX = '{12'd0, 12'd0, 1'b0, 13'd0, 3'd0, 1'b0, 1'b1};
	localparam pixel_t ANY_PIX     = '0;

	logic clk = 1'b0;
	logic arst_n;

	lps_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
	lps_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

	line_pixel_stepper #(
		.COORD_BITS  (COORD_BITS),
		.PAGE_WIDTH  (PAGE_WIDTH),
		.PAGE_HEIGHT (PAGE_HEIGHT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pix    (pix_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	pixel_t pixel_q [$];
	bit     mismatch_seen = 1'b0;
	bit     hold_request  = 1'b0;
	int     sent_count    = 0;
	int     send_idle_pct = 25;
	int     recv_idle_pct = 60;

	// line tracer state
	int trk_x   = 0;
	int trk_y   = 0;
	int goal_x  = 0;
	int goal_y  = 0;
	int run_x   = 0;
	int run_y   = 0;
	int err_acc = 0;
	bit x_back  = 1'b0;
	bit y_back  = 1'b0;
	bit tracing = 1'b0;

	cmd_row_t plan [25] = '{
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b1, NO_LINE_PIX},
		'{OP_LOAD,    12'd0,   12'd0,  12'd0,   12'd0,   1'b1,
			'{12'd0, 12'd0, 1'b1, 13'd0, 3'd7, 1'b1, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b1, NO_LINE_PIX},
		'{OP_LOAD,    12'd383, 12'd95, 12'd383, 12'd95,  1'b1,
			'{12'd383, 12'd95, 1'b1, 13'd4607, 3'd0, 1'b1, 1'b0}},
		'{OP_LOAD,    C_MIN,   C_MIN,  C_MAX,   C_MAX,   1'b1,
			'{C_MIN, C_MIN, 1'b0, 13'd0, 3'd0, 1'b0, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, C_MAX,   C_MIN,  C_MAX,   C_MIN,   1'b0, ANY_PIX},
		'{OP_LOAD,    C_MAX,   C_MIN,  C_MIN,   C_MAX,   1'b1,
			'{C_MAX, C_MIN, 1'b0, 13'd0, 3'd0, 1'b0, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_LOAD,    12'd384, 12'd0,  12'd380, 12'd2,   1'b1,
			'{12'd384, 12'd0, 1'b0, 13'd0, 3'd0, 1'b0, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b1, NO_LINE_PIX},
		'{OP_LOAD,    12'd5,   12'd2,  12'd7,   12'd10,  1'b1,
			'{12'd5, 12'd2, 1'b1, 13'd96, 3'd2, 1'b0, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_LOAD,    12'd10,  12'd95, 12'd10,  12'd96,  1'b1,
			'{12'd10, 12'd95, 1'b1, 13'd4561, 3'd5, 1'b0, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_LOAD,    12'd0,   12'hFFF, 12'd0,  12'hFFF, 1'b1,
			'{12'd0, 12'hFFF, 1'b0, 13'd0, 3'd0, 1'b1, 1'b0}},
		'{OP_LOAD,    12'hFFF, 12'd0,  12'd3,   12'd0,   1'b1,
			'{12'hFFF, 12'd0, 1'b0, 13'd0, 3'd0, 1'b0, 1'b0}},
		'{OP_ADVANCE, 12'd0,   12'd0,  12'd0,   12'd0,   1'b0, ANY_PIX},
		'{OP_LOAD,    C_MAX,   C_MAX,  C_MAX,   C_MAX,   1'b1,
			'{C_MAX, C_MAX, 1'b0, 13'd0, 3'd0, 1'b1, 1'b0}}
	};

	function automatic pixel_t trace_pixel(input logic op,
			input logic [11:0] sx, sy, fx, fy);
		pixel_t out_pix;
		int     x0, y0, x1, y1, e2, err, lin;
		out_pix = '0;
		if (op == OP_LOAD) begin
			x0 = $signed(sx);
			y0 = $signed(sy);
			x1 = $signed(fx);
			y1 = $signed(fy);
			trk_x   = x0;
			trk_y   = y0;
			goal_x  = x1;
			goal_y  = y1;
			run_x   = (x1 > x0) ? x1 - x0 : x0 - x1;
			run_y   = (y1 > y0) ? y1 - y0 : y0 - y1;
			x_back  = !(x0 < x1);
			y_back  = !(y0 < y1);
			err_acc = run_x - run_y;
		end else if (!tracing) begin
			out_pix.no_line = 1'b1;
			return out_pix;
		end else begin
			e2  = 2 * err_acc;
			err = err_acc;
			if (e2 > -run_y) begin
				err   -= run_y;
				trk_x += x_back ? -1 : 1;
			end
			if (e2 < run_x) begin
				err   += run_x;
				trk_y += y_back ? -1 : 1;
			end
			err_acc = err;
		end
		out_pix.px   = trk_x[11:0];
		out_pix.py   = trk_y[11:0];
		out_pix.last = (trk_x == goal_x) && (trk_y == goal_y);
		out_pix.vis  = trk_x >= 0 && trk_x < PAGE_WIDTH && trk_y >= 0 && trk_y < PAGE_HEIGHT;
		if (out_pix.vis) begin
			lin = trk_y * PAGE_WIDTH + trk_x;
			out_pix.byte_idx = 13'(lin >> 3);
			out_pix.bit_pos  = 3'(7 - (lin % 8));
		end
		tracing = !out_pix.last;
		return out_pix;
	endfunction

	function automatic logic [11:0] pick_coord(input int span);
		if ($urandom_range(1) == 0) begin
			return 12'($urandom_range(span) - 20);
		end
		return 12'($urandom);
	endfunction

	function automatic logic [11:0] nudge(input logic [11:0] c);
		int v;
		v = $signed(c);
		v = v + int'($urandom_range(24)) - 12;
		if (v > 2047) v = 2047;
		if (v < -2048) v = -2048;
		return 12'(v);
	endfunction

	task automatic issue_cmd(input logic op, input logic [11:0] sx, sy, fx, fy,
			input logic known, input pixel_t typed);
		pixel_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.opcode   <= op;
		cmd_ch.start_x  <= sx;
		cmd_ch.start_y  <= sy;
		cmd_ch.finish_x <= fx;
		cmd_ch.finish_y <= fy;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pred = trace_pixel(op, sx, sy, fx, fy);
		pixel_q.push_back(known ? typed : pred);
		sent_count++;
	endtask

	task automatic run_random();
		int          kind, steps, n, ax, ay;
		logic [11:0] sx, sy, fx, fy;
		while (sent_count < ITEM_TOTAL) begin
			if (sent_count < 170) begin
				send_idle_pct = 25;
				recv_idle_pct = 60;
			end else if (sent_count < 310) begin
				send_idle_pct = 60;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = $urandom_range(99);
			if (kind < 85) begin
				sx = pick_coord(420);
				sy = pick_coord(130);
				if (kind < 70) begin
					fx = nudge(sx);
					fy = nudge(sy);
				end else begin
					fx = 12'($urandom);
					fy = 12'($urandom);
				end
				ax = $signed(fx) - $signed(sx);
				ay = $signed(fy) - $signed(sy);
				if (ax < 0) ax = -ax;
				if (ay < 0) ay = -ay;
				steps = (ax > ay) ? ax : ay;
				if (kind >= 70) begin
					n = $urandom_range(1, 20);
				end else if ($urandom_range(9) == 0) begin
					n = $urandom_range(0, steps);
				end else begin
					n = steps + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
				end
				issue_cmd(OP_LOAD, sx, sy, fx, fy, 1'b0, ANY_PIX);
				repeat (n) begin
					issue_cmd(OP_ADVANCE, 12'($urandom), 12'($urandom), 12'($urandom),
						12'($urandom), 1'b0, ANY_PIX);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					issue_cmd(1'($urandom_range(1)), 12'($urandom), 12'($urandom),
						12'($urandom), 12'($urandom), 1'b0, ANY_PIX);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_seen = 1'b1;
		end
	endtask

	always @(posedge clk) begin : pix_check
		pixel_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: pixel beat with none expected, actual x=%0d y=%0d", $time,
					pix_ch.pixel_x, pix_ch.pixel_y);
				mismatch_seen = 1'b1;
			end else begin
				want = pixel_q.pop_front();
				check_field("pixel_x", $signed(want.px), pix_ch.pixel_x);
				check_field("pixel_y", $signed(want.py), pix_ch.pixel_y);
				check_field("visible", want.vis, pix_ch.visible);
				check_field("byte_index", want.byte_idx, pix_ch.byte_index);
				check_field("bit_position", want.bit_pos, pix_ch.bit_position);
				check_field("last_pixel", want.last, pix_ch.last_pixel);
				check_field("no_line", want.no_line, pix_ch.no_line);
			end
		end
	end

	initial begin
		pix_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// hold off so the pipeline fills and stalls the command side
				hold_request = 1'b0;
				pix_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			end
			pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		arst_n          <= 1'b0;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.opcode   <= OP_LOAD;
		cmd_ch.start_x  <= '0;
		cmd_ch.start_y  <= '0;
		cmd_ch.finish_x <= '0;
		cmd_ch.finish_y <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			issue_cmd(plan[i].op, plan[i].sx, plan[i].sy, plan[i].fx, plan[i].fy,
				plan[i].known, plan[i].want);
		end
		hold_request = 1'b1;
		run_random();
		cmd_ch.valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (!mismatch_seen) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
